### rtl/wrc_pkg.sv
`timescale 1ns / 1ps

package wrc_pkg;

  // Window length is a power of two: slot index and the Q8 average are bit slices
  localparam int WIN_LOG2       = 4;
  localparam int WINDOW_SECONDS = 1 << WIN_LOG2;
  localparam int SLOT_AW        = WIN_LOG2;
  localparam int DATA_W         = 32;
  localparam int SUM_W          = DATA_W + WIN_LOG2;
  localparam int AVG_W          = 40;
  localparam int Q_SHIFT        = 8 - WIN_LOG2;

  typedef logic [SLOT_AW-1:0] slot_addr_t;
  typedef logic [DATA_W-1:0]  data_t;
  typedef logic [SUM_W-1:0]   sum_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DEC,
    ST_SWEEP,
    ST_FIN
  } wrc_state_t;

  typedef struct packed {
    logic       rd_a_en;
    slot_addr_t rd_a_addr;
    logic       rd_b_en;
    slot_addr_t rd_b_addr;
    logic       wr_en;
    slot_addr_t wr_addr;
    data_t      wr_data;
    logic       clr_all;
  } ram_req_t;

  typedef struct packed {
    logic  load;
    data_t prev_total;
    sum_t  sum;
  } result_t;

endpackage

### rtl/wrc_slot_ram.sv
`timescale 1ns / 1ps

module wrc_slot_ram import wrc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  ram_req_t req,
  output data_t    rd_a_data,
  output data_t    rd_b_data
);

  data_t                       slot_mem [WINDOW_SECONDS];
  logic [WINDOW_SECONDS-1:0]   valid_r;
  logic [WINDOW_SECONDS-1:0]   valid_nxt;
  data_t                       rd_a_data_r;
  data_t                       rd_b_data_r;

  // Valid bits: an unwritten or cleared slot reads as zero
  always_comb begin
    valid_nxt = valid_r;
    if (req.clr_all) begin
      valid_nxt = '0;
    end
    if (req.wr_en) begin
      valid_nxt[req.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      slot_mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_a_en) begin
      rd_a_data_r <= valid_r[req.rd_a_addr] ? slot_mem[req.rd_a_addr] : '0;
    end
    if (req.rd_b_en) begin
      rd_b_data_r <= valid_r[req.rd_b_addr] ? slot_mem[req.rd_b_addr] : '0;
    end
  end

  assign rd_a_data = rd_a_data_r;
  assign rd_b_data = rd_b_data_r;

endmodule

### rtl/wrc_seq.sv
`timescale 1ns / 1ps

module wrc_seq import wrc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  data_t    in_now_second,
  input  data_t    in_amount,
  input  logic     out_free,
  output ram_req_t ram_req,
  input  data_t    rd_a_data,
  input  data_t    rd_b_data,
  output result_t  res
);

  wrc_state_t state_r, state_nxt;
  data_t      now_r, now_nxt;
  data_t      amt_r, amt_nxt;
  data_t      last_r, last_nxt;
  sum_t       sum_r, sum_nxt;
  data_t      prev_r, prev_nxt;
  slot_addr_t k_r, k_nxt;
  slot_addr_t pk_r, pk_nxt;
  logic       pend_r, pend_nxt;

  slot_addr_t        idx;
  logic [DATA_W:0]   diff;
  logic [DATA_W:0]   sat_sum;
  logic              is_same;
  logic              is_next;
  logic              is_big;
  data_t             new_val;

  assign idx     = now_r[SLOT_AW-1:0];
  assign diff    = {1'b0, now_r} - {1'b0, last_r};
  assign is_same = (now_r == last_r);
  assign is_next = !diff[DATA_W] && (diff[DATA_W-1:0] == data_t'(1));
  assign is_big  = diff[DATA_W] || (diff[DATA_W-1:0] > data_t'(WINDOW_SECONDS));
  assign sat_sum = {1'b0, rd_a_data} + {1'b0, amt_r};
  assign new_val = is_same ? (sat_sum[DATA_W] ? '1 : sat_sum[DATA_W-1:0]) : amt_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        if (is_same || is_next || is_big) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (k_r == idx) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    in_ready       = 1'b0;
    ram_req        = '0;
    res.load       = 1'b0;
    res.prev_total = prev_r;
    res.sum        = sum_r;
    now_nxt        = now_r;
    amt_nxt        = amt_r;
    last_nxt       = last_r;
    sum_nxt        = sum_r;
    prev_nxt       = prev_r;
    k_nxt          = k_r;
    pk_nxt         = pk_r;
    pend_nxt       = pend_r;
    case (state_r)
      ST_IDLE: begin
        in_ready          = 1'b1;
        ram_req.rd_a_en   = in_valid;
        ram_req.rd_a_addr = in_now_second[SLOT_AW-1:0];
        ram_req.rd_b_en   = in_valid;
        ram_req.rd_b_addr = in_now_second[SLOT_AW-1:0] - slot_addr_t'(1);
        if (in_valid) begin
          now_nxt = in_now_second;
          amt_nxt = in_amount;
        end
      end
      ST_DEC: begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = idx;
        ram_req.wr_data = new_val;
        ram_req.clr_all = is_big;
        last_nxt        = now_r;
        k_nxt           = last_r[SLOT_AW-1:0] + slot_addr_t'(1);
        pend_nxt        = 1'b0;
        // previous second lies inside any cleared gap
        prev_nxt        = (is_same || is_next) ? rd_b_data : '0;
        if (is_big) begin
          sum_nxt = sum_t'(amt_r);
        end else begin
          sum_nxt = sum_r - sum_t'(rd_a_data) + sum_t'(new_val);
        end
      end
      ST_SWEEP: begin
        if (pend_r) begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = pk_r;
          ram_req.wr_data = '0;
          sum_nxt         = sum_r - sum_t'(rd_a_data);
        end
        if (k_r != idx) begin
          ram_req.rd_a_en   = 1'b1;
          ram_req.rd_a_addr = k_r;
          pk_nxt            = k_r;
          pend_nxt          = 1'b1;
          k_nxt             = k_r + slot_addr_t'(1);
        end else begin
          pend_nxt = 1'b0;
        end
      end
      ST_FIN: begin
        res.load = out_free;
      end
      default: begin
        pend_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      last_r  <= '0;
      sum_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
      sum_r   <= sum_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r  <= now_nxt;
    amt_r  <= amt_nxt;
    prev_r <= prev_nxt;
    k_r    <= k_nxt;
    pk_r   <= pk_nxt;
  end

`ifndef SYNTH
  a_accept_to_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid) |=> (state_r == ST_DEC))
    else $error("accepted word did not move to decode");

  a_no_rw_same_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_req.wr_en && ram_req.rd_a_en) |-> (ram_req.wr_addr != ram_req.rd_a_addr))
    else $error("read and write hit the same slot in one cycle");

  a_sweep_spares_new: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP && pend_r) |-> (pk_r != idx))
    else $error("gap sweep cleared the slot of the current second");
`endif

endmodule

### rtl/windowed_rate_counter.sv
`timescale 1ns / 1ps

// Windowed rate counter: keeps a ring of WINDOW_SECONDS per-second totals in a
// small slot memory (two registered read ports, one write port, per-slot valid
// bits cleared at reset, so no clearing pass is needed). Each input word gives
// the current second and an amount; each accepted word yields exactly one
// result word with the total of the second before the latest one and the window
// average as unsigned Q8 (sum * 256 / WINDOW_SECONDS, truncated). A word for the
// same second, the next second, a jump backwards or a jump beyond the window
// goes from idle through decode to finish and back to idle. A forward jump of
// g seconds (2 <= g <= WINDOW_SECONDS, 16 by default) adds a sweep state
// between decode and finish: the sweep reads and zeroes one skipped slot per cycle
// through one memory read port. A result waiting in the output register holds
// the finish state only if it is still not taken when the next one is ready.
module windowed_rate_counter import wrc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [DATA_W-1:0]    in_now_second,
  input  logic [DATA_W-1:0]    in_amount,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [DATA_W-1:0]    out_previous_second_total,
  output logic [AVG_W-1:0]     out_window_average_q8
);

  ram_req_t ram_req;
  data_t    rd_a_data;
  data_t    rd_b_data;
  result_t  res;
  logic     out_free;

  logic               out_valid_r, out_valid_nxt;
  data_t              out_prev_r;
  logic [AVG_W-1:0]   out_avg_r;

  // Output slot is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ready;

  wrc_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_now_second (in_now_second),
    .in_amount     (in_amount),
    .out_free      (out_free),
    .ram_req       (ram_req),
    .rd_a_data     (rd_a_data),
    .rd_b_data     (rd_b_data),
    .res           (res)
  );

  wrc_slot_ram u_ram (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (ram_req),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  // Hold the result word until taken; load a new one when the slot frees up
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Q8 average: scale the running sum by 256 / WINDOW_SECONDS as a left shift
  always_ff @(posedge clk) begin
    if (res.load) begin
      out_prev_r <= res.prev_total;
      out_avg_r  <= AVG_W'(res.sum) << Q_SHIFT;
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_previous_second_total = out_prev_r;
  assign out_window_average_q8     = out_avg_r;

endmodule
